// ===== hw/rtl/tpl_pkg.sv =====
// Shared types, constants and codes for the transport position block.
package tpl_pkg;

	localparam int POS_W   = 48;
	localparam int OUT_W   = 48;
	localparam int LOOP_W  = 47;
	localparam int ELAP_W  = 16;
	localparam int RAW_W   = (POS_W > OUT_W) ? POS_W : OUT_W;
	localparam int DIV_W   = RAW_W + 1;
	localparam int CNT_W   = $clog2(DIV_W + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic signed [RAW_W:0] POS_MAX =
		{{(RAW_W - POS_W + 2){1'b0}}, {(POS_W - 1){1'b1}}};
	localparam logic signed [RAW_W:0] POS_MIN = ~POS_MAX;

	typedef enum logic [2:0] {
		MODE_TICK      = 3'd0,
		MODE_PLAY      = 3'd1,
		MODE_STOP      = 3'd2,
		MODE_TOGGLE_RC = 3'd3,
		MODE_START_RC  = 3'd4,
		MODE_STOP_RC   = 3'd5,
		MODE_SET_POS   = 3'd6,
		MODE_SET_ARM   = 3'd7
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_EN    = 2'd0,
		REG_LOOP_START = 2'd1,
		REG_LOOP_END   = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_PREP,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic div_step;
		logic fix;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic fold_needed;
		logic div_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== hw/rtl/transport_position_with_loop_unit.sv =====
// Top level of the transport position block with loop fold.
//
// Input channel (in_valid/in_stall) carries one item: a tick with elapsed
// samples or a transport command selected by mode. Every item yields exactly
// one result item on the output channel (out_valid/out_stall): the reported
// position and the playing, recording, armed and loop-active flags.
// Items are handled one at a time. An item that needs no loop fold passes
// from accept through update and prepare to the result; with the loop active
// while playing (or on the stop that freezes the folded position) a fold and
// a fix step follow prepare, the fold run by the bit-serial remainder unit
// that retires one bit of the 49-bit offset from loop_start per cycle.
// in_stall is low only while the block is idle.
// The result register frees the input side: a new item is taken while an
// earlier result still waits; a held result keeps the next one in the
// datapath until out_stall drops, and the payload stays put while stalled.
// Configuration (cfg_we, cfg_index, cfg_data) writes loop_enable (0),
// loop_start (1) and loop_end (2); other indexes are ignored. Write it only
// while no item is in flight.
// Asynchronous reset (arst_n low) stops the transport, clears record and
// arm, zeroes the position and the loop registers, and drops out_valid.
module transport_position_with_loop_unit import tpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [LOOP_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              mode,
	input  logic [ELAP_W-1:0]       elapsed_samples,
	input  logic signed [OUT_W-1:0] new_position,
	input  logic                    arm_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] position,
	output logic                    is_playing,
	output logic                    is_recording,
	output logic                    is_armed,
	output logic                    loop_active
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tpl_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.elapsed_samples (elapsed_samples),
		.new_position    (new_position),
		.arm_value       (arm_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.position        (position),
		.is_playing      (is_playing),
		.is_recording    (is_recording),
		.is_armed        (is_armed),
		.loop_active     (loop_active)
	);

endmodule

// ===== hw/rtl/tpl_ctrl.sv =====
// Sequencer for the transport position block: accept, update, fold, emit.
module tpl_ctrl import tpl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_n    = ST_PREP;
			end
			ST_PREP: begin
				if (sts.fold_needed) begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV;
				end else begin
					state_n = ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_n = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_n = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/tpl_dp.sv =====
// Datapath: config, transport flags, position, bit-serial loop fold, result register.
module tpl_dp import tpl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_sts_t                 sts,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [LOOP_W-1:0]       cfg_data,
	input  logic [2:0]              mode,
	input  logic [ELAP_W-1:0]       elapsed_samples,
	input  logic signed [OUT_W-1:0] new_position,
	input  logic                    arm_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] position,
	output logic                    is_playing,
	output logic                    is_recording,
	output logic                    is_armed,
	output logic                    loop_active
);

	logic                    loop_en_q;
	logic [LOOP_W-1:0]       loop_start_q, loop_end_q;
	logic                    running_q, capturing_q, armed_q, run_old_q;
	logic signed [RAW_W-1:0] raw_q;
	mode_t                   mode_q;
	logic [ELAP_W-1:0]       elapsed_q;
	logic signed [OUT_W-1:0] newpos_q;
	logic                    arm_val_q;
	logic [LOOP_W-1:0]       rem_q;
	logic [DIV_W-1:0]        mag_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [LOOP_W-1:0]       fold_q;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] position_q;
	logic                    playing_q, recording_q, armed_out_q, loop_act_q;

	logic                    act;
	logic [LOOP_W-1:0]       len;
	logic                    run_n, cap_n, arm_n;
	logic signed [RAW_W-1:0] raw_n;
	logic signed [RAW_W:0]   tick_sum, np_ext, diff;
	logic [LOOP_W:0]         shifted;
	logic [LOOP_W-1:0]       rem_n, adj;
	logic [LOOP_W-1:0]       fold;

	assign act = loop_en_q && (loop_end_q > loop_start_q);
	assign len = loop_end_q - loop_start_q;

	assign tick_sum = {raw_q[RAW_W-1], raw_q} + {{(RAW_W + 1 - ELAP_W){1'b0}}, elapsed_q};
	assign np_ext   = {{(RAW_W + 1 - OUT_W){newpos_q[OUT_W-1]}}, newpos_q};
	assign diff     = {raw_q[RAW_W-1], raw_q} - {{(RAW_W + 1 - LOOP_W){1'b0}}, loop_start_q};

	always_comb begin
		run_n = running_q;
		cap_n = capturing_q;
		arm_n = armed_q;
		raw_n = raw_q;
		unique case (mode_q)
			MODE_TICK: begin
				if (running_q) begin
					raw_n = (tick_sum > POS_MAX) ? RAW_W'(POS_MAX) : tick_sum[RAW_W-1:0];
				end
			end
			MODE_PLAY: run_n = 1'b1;
			MODE_STOP: run_n = 1'b0;
			MODE_TOGGLE_RC: begin
				arm_n = 1'b1;
				if (capturing_q) begin
					cap_n = 1'b0;
					run_n = 1'b0;
				end else begin
					cap_n = 1'b1;
					run_n = 1'b1;
				end
			end
			MODE_START_RC: begin
				if (armed_q) begin
					cap_n = 1'b1;
					run_n = 1'b1;
				end
			end
			MODE_STOP_RC: begin
				if (capturing_q) begin
					cap_n = 1'b0;
					run_n = 1'b0;
				end
			end
			MODE_SET_POS: begin
				priority if (np_ext > POS_MAX) begin
					raw_n = RAW_W'(POS_MAX);
				end else if (np_ext < POS_MIN) begin
					raw_n = RAW_W'(POS_MIN);
				end else begin
					raw_n = np_ext[RAW_W-1:0];
				end
			end
			MODE_SET_ARM: arm_n = arm_val_q;
			default: ;
		endcase
	end

	// restoring remainder step, one magnitude bit per cycle
	assign shifted = {rem_q, mag_q[DIV_W-1]};
	assign rem_n   = (shifted >= {1'b0, len}) ? LOOP_W'(shifted - {1'b0, len})
	                                          : shifted[LOOP_W-1:0];
	assign adj     = (neg_q && (rem_q != '0)) ? (len - rem_q) : rem_q;
	assign fold    = loop_start_q + adj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q    <= 1'b0;
			loop_start_q <= '0;
			loop_end_q   <= '0;
			running_q    <= 1'b0;
			capturing_q  <= 1'b0;
			armed_q      <= 1'b0;
			raw_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOOP_EN:    loop_en_q    <= cfg_data[0];
					REG_LOOP_START: loop_start_q <= cfg_data;
					REG_LOOP_END:   loop_end_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.update) begin
				running_q   <= run_n;
				capturing_q <= cap_n;
				armed_q     <= arm_n;
				raw_q       <= raw_n;
			end
			if (cmd.fix && !running_q) begin
				raw_q <= RAW_W'(fold);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= mode_t'(mode);
			elapsed_q <= elapsed_samples;
			newpos_q  <= new_position;
			arm_val_q <= arm_value;
		end
		if (cmd.update) begin
			run_old_q <= running_q;
		end
		if (cmd.div_start) begin
			neg_q <= diff[RAW_W];
			mag_q <= diff[RAW_W] ? DIV_W'(-diff) : DIV_W'(diff);
			rem_q <= '0;
			cnt_q <= CNT_W'(DIV_W);
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			mag_q <= {mag_q[DIV_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.fix) begin
			fold_q <= fold;
		end
		if (cmd.emit) begin
			position_q  <= sts.fold_needed ? OUT_W'(fold_q) : raw_q[OUT_W-1:0];
			playing_q   <= running_q;
			recording_q <= capturing_q;
			armed_out_q <= armed_q;
			loop_act_q  <= act;
		end
	end

	assign sts.fold_needed = act && (run_old_q || running_q);
	assign sts.div_last    = (cnt_q == CNT_W'(1));
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign position     = position_q;
	assign is_playing   = playing_q;
	assign is_recording = recording_q;
	assign is_armed     = armed_out_q;
	assign loop_active  = loop_act_q;

endmodule

// ===== hw/rtl/tpl_checker.sv =====
// Port-level checks for the transport position block, bound to the top level.
module tpl_checker import tpl_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] position,
	input logic                    is_playing,
	input logic                    loop_active
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while busy");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item appeared while idle");

	a_loop_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_playing && loop_active |-> !position[OUT_W-1])
		else $error("folded position is negative");

endmodule

bind transport_position_with_loop_unit tpl_checker u_tpl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.position    (position),
	.is_playing  (is_playing),
	.loop_active (loop_active)
);
